>>> hw/rtl/remote_code_frame_generator_defines.svh
// ----------------------------------------------------------------------------
// remote code frame generator assertion macros
// shared check macros for the remote code frame generator
// ----------------------------------------------------------------------------
`ifndef REMOTE_CODE_FRAME_GENERATOR_DEFINES_SVH
`define REMOTE_CODE_FRAME_GENERATOR_DEFINES_SVH

// check outside reset
`define RCFG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcfg check failed");

// check at every edge, reset included
`define RCFG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rcfg check failed");

`endif

>>> hw/rtl/rcfg_pkg.sv
// ----------------------------------------------------------------------------
// rcfg_pkg
// shared types and constants of the remote code frame generator
// ----------------------------------------------------------------------------
package rcfg_pkg;

    localparam int CODE_BITS   = 12;
    localparam int CODE_IN_W   = 12;
    localparam int CODE_EXT_W  = 16;
    localparam int RELOAD_W    = 16;
    localparam int REPEAT_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    localparam int POS_W = $clog2(2 * CODE_BITS + 3);
    localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    localparam logic [POS_W-1:0] POS_START = POS_W'(2 * CODE_BITS + 2);
    localparam logic [POS_W-1:0] POS_PULSE = POS_W'(2 * CODE_BITS + 1);
    localparam logic [POS_W-1:0] POS_PAUSE = '0;

    localparam logic [RELOAD_W-1:0] PAUSE_RELOAD_RST  = 16'hD3F0;
    localparam logic [REPEAT_W-1:0] FRAME_REPEATS_RST = 8'd5;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_HIGH      = 3'd0,
        REG_ONE_LOW       = 3'd1,
        REG_ZERO_HIGH     = 3'd2,
        REG_ZERO_LOW      = 3'd3,
        REG_PAUSE         = 3'd4,
        REG_FRAME_REPEATS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [RELOAD_W-1:0] one_high_reload;
        logic [RELOAD_W-1:0] one_low_reload;
        logic [RELOAD_W-1:0] zero_high_reload;
        logic [RELOAD_W-1:0] zero_low_reload;
        logic [RELOAD_W-1:0] pause_reload;
        logic [REPEAT_W-1:0] frame_repeats;
    } cfg_regs_t;

    // line_level in the lowest bit
    typedef struct packed {
        logic                active;
        logic [RELOAD_W-1:0] interval_reload;
        logic                line_level;
    } result_t;

endpackage

>>> hw/rtl/rcfg_engine.sv
// ----------------------------------------------------------------------------
// rcfg_engine
// frame sequencer: phase position, code and frame count, next interval result
// ----------------------------------------------------------------------------
module rcfg_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          cmd,
    input  logic [rcfg_pkg::CODE_IN_W-1:0] code_word,
    input  rcfg_pkg::cfg_regs_t           cfg,
    output rcfg_pkg::result_t             result
);

    import rcfg_pkg::*;

    logic [REPEAT_W-1:0]   frames_left_reg;
    logic [REPEAT_W-1:0]   frames_left_next;
    logic [POS_W-1:0]      phase_pos_reg;
    logic [POS_W-1:0]      phase_pos_next;
    logic [CODE_BITS-1:0]  code_reg;
    logic [CODE_BITS-1:0]  code_next;
    logic [POS_W-1:0]      pos_dec;
    logic [POS_W-1:0]      pos_less1;
    logic [IDX_W-1:0]      bit_idx;
    logic [CODE_EXT_W-1:0] code_ext;
    logic                  bit_one;
    logic                  level;
    logic [RELOAD_W-1:0]   reload;

    assign code_ext  = {{(CODE_EXT_W - CODE_IN_W){1'b0}}, code_word};
    assign pos_dec   = (phase_pos_reg != POS_PAUSE) ? phase_pos_reg - 1'b1 : phase_pos_reg;
    assign pos_less1 = pos_dec - 1'b1;
    assign bit_idx   = pos_less1[IDX_W:1];
    assign bit_one   = code_reg[bit_idx];

    always_comb
    begin
        frames_left_next = frames_left_reg;
        phase_pos_next   = phase_pos_reg;
        code_next        = code_reg;
        level            = 1'b0;
        reload           = '0;
        if (cmd == CMD_START)
        begin
            frames_left_next = cfg.frame_repeats;
            phase_pos_next   = POS_START;
            code_next        = code_ext[CODE_BITS-1:0];
        end
        else if (frames_left_reg != '0)
        begin
            phase_pos_next = pos_dec;
            if (pos_dec == POS_PULSE)
            begin
                level  = 1'b1;
                reload = cfg.one_high_reload;
            end
            else if (pos_dec == POS_PAUSE)
            begin
                reload           = cfg.pause_reload;
                frames_left_next = frames_left_reg - 1'b1;
                phase_pos_next   = POS_START;
            end
            else if (!pos_dec[0])
            begin
                reload = bit_one ? cfg.one_low_reload : cfg.zero_low_reload;
            end
            else
            begin
                level  = 1'b1;
                reload = bit_one ? cfg.one_high_reload : cfg.zero_high_reload;
            end
        end
    end

    assign result.line_level      = level;
    assign result.interval_reload = reload;
    assign result.active          = (frames_left_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_left_reg <= '0;
            phase_pos_reg   <= '0;
            code_reg        <= '0;
        end
        else if (step)
        begin
            frames_left_reg <= frames_left_next;
            phase_pos_reg   <= phase_pos_next;
            code_reg        <= code_next;
        end
    end

endmodule

>>> hw/rtl/remote_code_frame_generator.sv
// ----------------------------------------------------------------------------
// remote_code_frame_generator
// pulse-width remote control code frame generator with stream ports
// ----------------------------------------------------------------------------
// A start beat (tuser 0) loads a code word and restarts the frame sequence;
// each tick beat (tuser 1) marks the end of the running interval and returns
// the line level and timer reload for the next one. One beat is taken every
// clock cycle while the skid stage is empty, and its result is registered in
// the result register before it reaches the output. When the output side
// stalls, a skid stage behind the result register takes one more beat, and
// the input then waits until the held result has moved on.
// Configuration writes are taken every cycle.
module remote_code_frame_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rcfg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // code_word, zero pad
    input  logic                            s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rcfg_pkg::OUT_DATA_W-1:0] m_axis_tdata   // line_level, interval_reload, active
);

    import rcfg_pkg::*;

    `include "remote_code_frame_generator_defines.svh"

    cfg_regs_t cfg_reg;
    result_t   result;
    result_t   out_data_reg;
    result_t   out_data_next;
    result_t   skid_data_reg;
    result_t   skid_data_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      in_beat;
    logic      out_stall;
    logic      last_pause_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high_reload  <= '0;
            cfg_reg.one_low_reload   <= '0;
            cfg_reg.zero_high_reload <= '0;
            cfg_reg.zero_low_reload  <= '0;
            cfg_reg.pause_reload     <= PAUSE_RELOAD_RST;
            cfg_reg.frame_repeats    <= FRAME_REPEATS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ONE_HIGH:      cfg_reg.one_high_reload  <= cfg_data;
                REG_ONE_LOW:       cfg_reg.one_low_reload   <= cfg_data;
                REG_ZERO_HIGH:     cfg_reg.zero_high_reload <= cfg_data;
                REG_ZERO_LOW:      cfg_reg.zero_low_reload  <= cfg_data;
                REG_PAUSE:         cfg_reg.pause_reload     <= cfg_data;
                REG_FRAME_REPEATS: cfg_reg.frame_repeats    <= cfg_data[REPEAT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    rcfg_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_beat),
        .cmd       (s_axis_tuser),
        .code_word (s_axis_tdata[CODE_IN_W-1:0]),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // result register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_beat;
                out_data_next  = result;
            end
        end
        else if (in_beat)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    assign out_stall       = out_valid_reg && !m_axis_tready;
    assign last_pause_beat = out_valid_reg && !out_data_reg.active
                             && (out_data_reg.interval_reload != '0);

    `RCFG_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg)
    `RCFG_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_reg) |-> $past(out_stall))
    `RCFG_ASSERT(a_pause_line_low, last_pause_beat |-> !out_data_reg.line_level)

endmodule
